[rtl/core/kiss_random_bit_pool_defines.svh]
// ----------------------------------------------------------------------------
// kiss_random_bit_pool_defines.svh
// Assertion macros for the random bit pool. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KISS_RANDOM_BIT_POOL_DEFINES_SVH
`define KISS_RANDOM_BIT_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define KRBP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define KRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KRBP_ASSERT(lbl, cond, msg)
`define KRBP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/krbp_pkg.sv]
// ----------------------------------------------------------------------------
// krbp_pkg
// Shared constants, types and helpers of the random bit pool.
// ----------------------------------------------------------------------------
package krbp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int WORD_W     = 32;
    localparam int LEFT_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int PW_W       = 5;
    localparam int MAX_BITS   = 32;

    localparam logic [WORD_W-1:0] COUNTER_STEP = 32'd1411392427;
    localparam logic [WORD_W-1:0] CARRY_MASK   = 32'd2147483647;
    localparam int SHIFT_A = 5;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_0,
        CFG_SEED_1,
        CFG_SEED_2,
        CFG_SEED_3,
        CFG_POOL_WORDS
    } t_cfg_idx;

    typedef enum logic {
        REQ_RESTART = 1'b0,
        REQ_DRAW    = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BIT,
        S_REFILL
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_gen_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] counter;
        logic [WORD_W-1:0] xorshift;
        logic [WORD_W-1:0] older;
        logic [WORD_W-1:0] newer;
    } t_seed;

    typedef struct packed {
        logic             clr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
    } t_pool_cmd;

    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] first_idx;
    } t_pool_stat;

    // Index of the last pool word in use; zero counts as one word, and the
    // count is capped at the pool depth.
    function automatic logic [IDX_W-1:0] last_in_use(input logic [PW_W-1:0] pw);
        if (pw == '0) begin
            return '0;
        end else if (int'(pw) > POOL_DEPTH) begin
            return IDX_W'(POOL_DEPTH - 1);
        end else begin
            return IDX_W'(pw - 1'b1);
        end
    endfunction

endpackage

[rtl/core/kiss_random_bit_pool.sv]
// ----------------------------------------------------------------------------
// kiss_random_bit_pool
// Random bit pool fed by a KISS-style generator; draws up to 32 bits a word.
//
//   channel   dir   handshake                  payload
//   s_axis    in    s_axis_tvalid/tready       tuser: kind, tdata: bit count
//   m_axis    out   m_axis_tvalid/tready       tdata: drawn bits
//   cfg       in    i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// A restart word is taken and gives no result. A draw word of B bits is
// served by the sequencer, which pulls one bit a cycle while a pool word
// is usable and, once all N pool words in use are empty, refills them,
// stepping the shared generator one word a cycle.
// Reset is synchronous and clears the generator, the seeds and the pool valid
// bits at once. A finished result waits in the output register; a new word
// is taken meanwhile, and a later draw holds in its last step until the
// output register is free.
// ----------------------------------------------------------------------------
`include "kiss_random_bit_pool_defines.svh"

module kiss_random_bit_pool (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [5:0] bit_count
    input  logic [0:0]                     s_axis_tuser,   // [0] req_type
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [31:0] random_bits
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [krbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import krbp_pkg::*;

    // Configuration registers.
    t_seed           r_seed;
    logic [PW_W-1:0] r_pool_words;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [WORD_W-1:0]  r_result, n_result;
    logic [IDX_W-1:0]   r_last_idx, n_last_idx;
    logic [IDX_W-1:0]   r_fill, n_fill;
    logic               r_use0, n_use0;

    // Output register.
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;
    logic               out_load;
    logic               out_free;

    // Shared units.
    t_gen_cmd           gen_cmd;
    logic [WORD_W-1:0]  gen_word;
    t_pool_cmd          pool_cmd;
    t_pool_stat         pool_stat;
    logic [WORD_W-1:0]  pool_wr_data;
    logic [WORD_W-1:0]  pool_rd_data;
    logic [IDX_W-1:0]   pool_rd_idx;

    logic               in_accept;
    logic [LEFT_W-1:0]  req_bits;

    // The configuration port never stalls; the user must write only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_pool_words <= PW_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEED_0:     r_seed.counter  <= i_cfg_data;
                CFG_SEED_1:     r_seed.xorshift <= i_cfg_data;
                CFG_SEED_2:     r_seed.older    <= i_cfg_data;
                CFG_SEED_3:     r_seed.newer    <= i_cfg_data;
                CFG_POOL_WORDS: r_pool_words    <= i_cfg_data[PW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    krbp_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (gen_cmd),
        .i_seed  (r_seed),
        .o_word  (gen_word)
    );

    krbp_pool u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (pool_cmd),
        .i_wr_data  (pool_wr_data),
        .i_rd_idx   (pool_rd_idx),
        .i_last_idx (r_last_idx),
        .o_rd_data  (pool_rd_data),
        .o_stat     (pool_stat)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Bit counts above the word width saturate.
    assign req_bits = (s_axis_tdata[LEFT_W-1:0] > LEFT_W'(MAX_BITS))
                    ? LEFT_W'(MAX_BITS) : s_axis_tdata[LEFT_W-1:0];

    // Right after a refill, word 0 is taken even when it came out zero.
    assign pool_rd_idx = r_use0 ? '0 : pool_stat.first_idx;

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_result     = r_result;
        n_last_idx   = r_last_idx;
        n_fill       = r_fill;
        n_use0       = r_use0;
        gen_cmd      = '0;
        pool_cmd     = '0;
        pool_cmd.wr_idx = pool_rd_idx;
        pool_wr_data = pool_rd_data >> 1;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (t_req'(s_axis_tuser[0]) == REQ_RESTART) begin
                        gen_cmd.load = 1'b1;
                        pool_cmd.clr = 1'b1;
                    end else begin
                        n_state    = S_BIT;
                        n_left     = req_bits;
                        n_result   = '0;
                        n_last_idx = last_in_use(r_pool_words);
                        n_use0     = 1'b0;
                    end
                end
            end
            S_BIT: begin
                if (r_left == '0) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (r_use0 || pool_stat.any) begin
                    // Take the low bit of the chosen word and shift it out.
                    pool_cmd.wr_en = 1'b1;
                    n_result = {r_result[WORD_W-2:0], pool_rd_data[0]};
                    n_left   = r_left - 1'b1;
                    n_use0   = 1'b0;
                end else begin
                    // Every word in use is empty: start a refill.
                    gen_cmd.step = 1'b1;
                    n_fill       = '0;
                    n_state      = S_REFILL;
                end
            end
            S_REFILL: begin
                pool_cmd.wr_en  = 1'b1;
                pool_cmd.wr_idx = r_fill;
                pool_wr_data    = gen_word;
                if (r_fill == r_last_idx) begin
                    n_state = S_BIT;
                    n_use0  = 1'b1;
                end else begin
                    gen_cmd.step = 1'b1;
                    n_fill       = r_fill + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_fill  <= '0;
            r_use0  <= 1'b0;
            r_last_idx <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_fill  <= n_fill;
            r_use0  <= n_use0;
            r_last_idx <= n_last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A refill never writes past the last word in use.
    `KRBP_ASSERT(a_fill_in_range, (r_state != S_REFILL) || (r_fill <= r_last_idx), "refill index out of range")
    // The bit counter never exceeds the word width.
    `KRBP_ASSERT(a_left_in_range, r_left <= LEFT_W'(MAX_BITS), "bit counter out of range")
    // After a restart the pool holds no usable word.
    `KRBP_ASSERT_NEXT(a_restart_clears, in_accept && (s_axis_tuser[0] == REQ_RESTART), !pool_stat.any, "pool not cleared by restart")
    // A draw always enters the bit extraction step.
    `KRBP_ASSERT_NEXT(a_draw_starts, in_accept && (s_axis_tuser[0] == REQ_DRAW), r_state == S_BIT, "draw did not start")

endmodule

[rtl/core/krbp_gen.sv]
// ----------------------------------------------------------------------------
// krbp_gen
// Generator state: additive counter, xorshift word and add-with-carry pair.
// ----------------------------------------------------------------------------
module krbp_gen (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  krbp_pkg::t_gen_cmd        i_cmd,
    input  krbp_pkg::t_seed           i_seed,
    output logic [krbp_pkg::WORD_W-1:0] o_word
);
    import krbp_pkg::*;

    logic [WORD_W-1:0] r_counter, n_counter;
    logic [WORD_W-1:0] r_xorshift, n_xorshift;
    logic [WORD_W-1:0] r_older, n_older;
    logic [WORD_W-1:0] r_newer, n_newer;
    logic              r_carry, n_carry;

    logic [WORD_W-1:0] xs_a, xs_b, awc_sum;

    always_comb begin
        xs_a    = r_xorshift ^ (r_xorshift << SHIFT_A);
        xs_b    = xs_a ^ (xs_a >> SHIFT_B);
        awc_sum = r_older + r_newer + WORD_W'(r_carry);

        n_counter  = r_counter;
        n_xorshift = r_xorshift;
        n_older    = r_older;
        n_newer    = r_newer;
        n_carry    = r_carry;
        if (i_cmd.load) begin
            n_counter  = i_seed.counter;
            n_xorshift = i_seed.xorshift;
            n_older    = i_seed.older;
            n_newer    = i_seed.newer;
            n_carry    = 1'b0;
        end else if (i_cmd.step) begin
            n_counter  = r_counter + COUNTER_STEP;
            n_xorshift = xs_b ^ (xs_b << SHIFT_C);
            n_older    = r_newer;
            n_newer    = awc_sum & CARRY_MASK;
            n_carry    = awc_sum[WORD_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_xorshift <= '0;
            r_older    <= '0;
            r_newer    <= '0;
            r_carry    <= 1'b0;
        end else begin
            r_counter  <= n_counter;
            r_xorshift <= n_xorshift;
            r_older    <= n_older;
            r_newer    <= n_newer;
            r_carry    <= n_carry;
        end
    end

    // The output word is formed from the state after the step.
    assign o_word = r_counter + r_xorshift + r_newer;

endmodule

[rtl/core/krbp_pool.sv]
// ----------------------------------------------------------------------------
// krbp_pool
// Pool words with per-word valid bits and a first-nonzero search.
// ----------------------------------------------------------------------------
module krbp_pool (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  krbp_pkg::t_pool_cmd         i_cmd,
    input  logic [krbp_pkg::WORD_W-1:0] i_wr_data,
    input  logic [krbp_pkg::IDX_W-1:0]  i_rd_idx,
    input  logic [krbp_pkg::IDX_W-1:0]  i_last_idx,
    output logic [krbp_pkg::WORD_W-1:0] o_rd_data,
    output krbp_pkg::t_pool_stat        o_stat
);
    import krbp_pkg::*;

    logic [WORD_W-1:0]     r_word [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] r_valid;
    logic [POOL_DEPTH-1:0] nonzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[i_cmd.wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_word[i_cmd.wr_idx] <= i_wr_data;
        end
    end

    // A word that was never written since the last clear reads as zero.
    assign o_rd_data = r_valid[i_rd_idx] ? r_word[i_rd_idx] : '0;

    always_comb begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
            nonzero[i] = r_valid[i] && (r_word[i] != '0);
        end
        o_stat = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (nonzero[i] && (IDX_W'(i) <= i_last_idx)) begin
                o_stat.any       = 1'b1;
                o_stat.first_idx = IDX_W'(i);
            end
        end
    end

endmodule
